// File: rtl/key_repeat_filter_event_fifo_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key repeat filter event FIFO
// Shared helpers so each check is written on one line.
// ----------------------------------------------------------------------------
`ifndef KEY_REPEAT_FILTER_EVENT_FIFO_DEFINES_SVH
`define KEY_REPEAT_FILTER_EVENT_FIFO_DEFINES_SVH

// Same-cycle implication
`define KRF_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication
`define KRF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: rtl/krf_pkg.sv
// ----------------------------------------------------------------------------
// krf_pkg
// Types and constants of the key repeat filter event FIFO.
// ----------------------------------------------------------------------------
package krf_pkg;

   // Event queue geometry
   localparam int FifoDepth = 16;
   localparam int PtrW      = $clog2(FifoDepth);
   localparam int CntW      = $clog2(FifoDepth + 1);
   localparam int FillW     = 5;

   // Field widths
   localparam int CodeW  = 16;
   localparam int ValueW = 32;
   localparam int TickW  = 32;
   localparam int MsW    = 16;
   localparam int CsrIdxW = 2;

   // Register reset values
   localparam logic [MsW-1:0] FirstRepeatRst = MsW'(250);
   localparam logic [MsW-1:0] NextRepeatRst  = MsW'(100);

   // Request codes
   typedef enum logic [1:0] {
      REQ_HW     = 2'd0,
      REQ_INJECT = 2'd1,
      REQ_POP    = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   // Event kind codes
   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_REPEAT = 2'd1;

   // Source code for injected events
   localparam logic [1:0] SRC_IR = 2'd0;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CSR_FIRST_MS   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_NEXT_MS    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CAPTURE_DIS = 2'd2;

   // One queued event (52 bits)
   typedef struct packed {
      logic [1:0]        kind;
      logic [CodeW-1:0]  code;
      logic [ValueW-1:0] value;
      logic [1:0]        source;
   } ev_entry_type;

endpackage

// File: rtl/krf_req_if.sv
// ----------------------------------------------------------------------------
// krf_req_if
// Request channel: hardware event, injected key or pop.
// ----------------------------------------------------------------------------
interface krf_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        req_type;
   logic [1:0]                        event_kind;
   logic [krf_pkg::CodeW-1:0]         event_code;
   logic signed [krf_pkg::ValueW-1:0] event_value;
   logic [1:0]                        event_source;
   logic [krf_pkg::TickW-1:0]         now_tick;

   modport source (output valid, req_type, event_kind, event_code, event_value,
                   event_source, now_tick, input ready);
   modport sink   (input valid, req_type, event_kind, event_code, event_value,
                   event_source, now_tick, output ready);
endinterface

// File: rtl/krf_rsp_if.sv
// ----------------------------------------------------------------------------
// krf_rsp_if
// Response channel: one response per request.
// ----------------------------------------------------------------------------
interface krf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              event_queued;
   logic                              dropped_full;
   logic                              pop_valid;
   logic [1:0]                        out_kind;
   logic [krf_pkg::CodeW-1:0]         out_code;
   logic signed [krf_pkg::ValueW-1:0] out_value;
   logic [1:0]                        out_source;
   logic [krf_pkg::FillW-1:0]         fill_level;

   modport source (output valid, event_queued, dropped_full, pop_valid, out_kind,
                   out_code, out_value, out_source, fill_level, input ready);
   modport sink   (input valid, event_queued, dropped_full, pop_valid, out_kind,
                   out_code, out_value, out_source, fill_level, output ready);
endinterface

// File: rtl/krf_csr_if.sv
// ----------------------------------------------------------------------------
// krf_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface krf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [krf_pkg::CsrIdxW-1:0] index;
   logic [krf_pkg::MsW-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/key_repeat_filter_event_fifo.sv
// ----------------------------------------------------------------------------
// key_repeat_filter_event_fifo
// Key auto-repeat filter in front of a ring FIFO of key events.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request: a hardware key event (filtered), an
//   injected key event (queued unfiltered, as a key from SRC_IR) or a pop of the oldest event.
//   rsp_chan returns exactly one response per request: queued / dropped
//   flags, the popped event when pop_valid is set, and the fill level.
//   csr_chan writes the repeat intervals and the capture disable bit; it is
//   always ready. It is to be written only while no request is outstanding; the block does not enforce this.
// Timing:
//   One request per cycle while no response waits on a low rsp_chan.ready.
//   The response is registered and shows up the cycle after acceptance. A
//   pop reads the event memory through its single synchronous read port at
//   the accept edge; that read register feeds the response directly.
// Reset and stall:
//   Synchronous reset empties the queue and clears the filter state; the
//   event memory itself is not cleared. While the response waits on a low
//   rsp_chan.ready, req_chan.ready stays low.
// ----------------------------------------------------------------------------
`include "key_repeat_filter_event_fifo_defines.svh"

module key_repeat_filter_event_fifo (
   input  logic clock,
   input  logic reset,
   krf_req_if.sink   req_chan,
   krf_rsp_if.source rsp_chan,
   krf_csr_if.sink   csr_chan
);
   import krf_pkg::*;

   // Configuration registers
   logic [MsW-1:0] first_ms_ff, next_ms_ff;
   logic           cap_dis_ff;

   // Filter state
   logic [CodeW-1:0] held_key_ff, held_key_in;
   logic             first_pend_ff, first_pend_in;
   logic [TickW-1:0] last_tick_ff, last_tick_in;

   // Queue state
   ev_entry_type     mem [FifoDepth];
   logic [PtrW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   ev_entry_type     rd_data_ff;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             queued_ff, queued_in;
   logic             dropped_ff, dropped_in;
   logic             pop_valid_ff, pop_valid_in;
   logic [FillW-1:0] fill_ff, fill_in;

   // Request decode and filter terms
   logic             req_acc;
   logic             full, empty;
   logic             push_req, push_go, pop_go;
   ev_entry_type     push_entry;
   logic             val_is0, val_is1, malformed, null_rel;
   logic [TickW-1:0] elapsed, limit;
   req_kind_type     req_kind;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign req_kind = req_kind_type'(req_chan.req_type);
   assign full     = (cnt_ff == CntW'(FifoDepth));
   assign empty    = (cnt_ff == '0);
   assign val_is0  = (req_chan.event_value == 32'sd0);
   assign val_is1  = (req_chan.event_value == 32'sd1);
   assign malformed = !(val_is0 || val_is1) && (req_chan.event_kind != KIND_REPEAT);
   assign null_rel  = val_is0 && (req_chan.event_code == '0);
   assign elapsed   = req_chan.now_tick - last_tick_ff;
   assign limit     = first_pend_ff ? TickW'(first_ms_ff) : TickW'(next_ms_ff);

   // Request side stalls only while the response waits
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Filter, push and pop decisions
   always_comb begin
      held_key_in   = held_key_ff;
      first_pend_in = first_pend_ff;
      last_tick_in  = last_tick_ff;
      push_req      = 1'b0;
      pop_go        = 1'b0;
      push_entry.kind   = req_chan.event_kind;
      push_entry.code   = req_chan.event_code;
      push_entry.value  = req_chan.event_value;
      push_entry.source = req_chan.event_source;

      case (req_kind)
         REQ_HW: begin
            if (!cap_dis_ff && !malformed && !null_rel) begin
               if (req_chan.event_kind == KIND_KEY) begin
                  push_req = 1'b1;
                  if (val_is1) begin
                     // press: latch key, start timing
                     held_key_in   = req_chan.event_code;
                     first_pend_in = 1'b1;
                     last_tick_in  = req_chan.now_tick;
                  end else begin
                     // release: report held key, clear filter
                     push_entry.code = held_key_ff;
                     held_key_in     = '0;
                     first_pend_in   = 1'b0;
                     last_tick_in    = '0;
                  end
               end else if (req_chan.event_kind == KIND_REPEAT) begin
                  if (elapsed != '0 && held_key_ff != '0 && elapsed > limit) begin
                     push_req         = 1'b1;
                     push_entry.code  = held_key_ff;
                     push_entry.value = ValueW'(1);
                     last_tick_in     = req_chan.now_tick;
                     first_pend_in    = 1'b0;
                  end
               end
            end
         end
         REQ_INJECT: begin
            push_req          = 1'b1;
            push_entry.kind   = KIND_KEY;
            push_entry.source = SRC_IR;
         end
         REQ_POP: begin
            pop_go = !empty;
         end
         default: begin
         end
      endcase
   end

   assign push_go = req_acc && push_req && !full;

   // Next pointers, count and response
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (push_go) begin
         tail_in = (tail_ff == PtrW'(FifoDepth - 1)) ? '0 : tail_ff + PtrW'(1);
         cnt_in  = cnt_ff + CntW'(1);
      end else if (req_acc && pop_go) begin
         head_in = (head_ff == PtrW'(FifoDepth - 1)) ? '0 : head_ff + PtrW'(1);
         cnt_in  = cnt_ff - CntW'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      queued_in    = queued_ff;
      dropped_in   = dropped_ff;
      pop_valid_in = pop_valid_ff;
      fill_in      = fill_ff;
      if (req_acc) begin
         rsp_valid_in = 1'b1;
         queued_in    = push_go;
         dropped_in   = push_req && full;
         pop_valid_in = pop_go;
         fill_in      = FillW'(cnt_in);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ms_ff   <= FirstRepeatRst;
         next_ms_ff    <= NextRepeatRst;
         cap_dis_ff    <= 1'b0;
         held_key_ff   <= '0;
         first_pend_ff <= 1'b0;
         last_tick_ff  <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         queued_ff     <= 1'b0;
         dropped_ff    <= 1'b0;
         pop_valid_ff  <= 1'b0;
         fill_ff       <= '0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_FIRST_MS:    first_ms_ff <= csr_chan.wdata;
               CSR_NEXT_MS:     next_ms_ff  <= csr_chan.wdata;
               CSR_CAPTURE_DIS: cap_dis_ff  <= csr_chan.wdata[0];
               default: begin
               end
            endcase
         end
         if (req_acc) begin
            held_key_ff   <= held_key_in;
            first_pend_ff <= first_pend_in;
            last_tick_ff  <= last_tick_in;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         queued_ff    <= queued_in;
         dropped_ff   <= dropped_in;
         pop_valid_ff <= pop_valid_in;
         fill_ff      <= fill_in;
      end
   end

   // Event memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push_go) begin
         mem[tail_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && pop_go) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   // Response payload; popped fields read as zero when nothing was popped
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_queued = queued_ff;
   assign rsp_chan.dropped_full = dropped_ff;
   assign rsp_chan.pop_valid    = pop_valid_ff;
   assign rsp_chan.out_kind     = pop_valid_ff ? rd_data_ff.kind   : '0;
   assign rsp_chan.out_code     = pop_valid_ff ? rd_data_ff.code   : '0;
   assign rsp_chan.out_value    = pop_valid_ff ? $signed(rd_data_ff.value) : '0;
   assign rsp_chan.out_source   = pop_valid_ff ? rd_data_ff.source : '0;
   assign rsp_chan.fill_level   = fill_ff;

   // Checks
   `KRF_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CntW'(FifoDepth))
   `KRF_ASSERT_NOW(a_ptr_meet, clock, reset, empty || full, head_ff == tail_ff)
   `KRF_ASSERT_NEXT(a_pop_dec, clock, reset, req_acc && pop_go, cnt_ff == $past(cnt_ff) - CntW'(1))
   `KRF_ASSERT_NOW(a_flag_excl, clock, reset, rsp_valid_ff, !(queued_ff && dropped_ff) && !(pop_valid_ff && (queued_ff || dropped_ff)))
   `KRF_ASSERT_NOW(a_stall_hold, clock, reset, rsp_valid_ff && !rsp_chan.ready, !req_chan.ready)

endmodule
